// File: rtl/upc_pkg.sv
`timescale 1ns / 1ps
// Shared types, character constants and helper functions for the URL percent codec.
// Used by every module of the codec; depends on nothing else.
package upc_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam int APB_AW = 3;
  localparam logic [APB_AW-1:0] ADDR_MODE = 3'd0;

  // One queued command: up to three output bytes for one input item.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    logic       last;
  } upc_cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Letters carry bit 6; their low nibble is their value minus nine.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
  endfunction

  function automatic logic passes(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A) || c == 8'h21 || c == 8'h27 ||
           c == 8'h28 || c == 8'h29 || c == 8'h2A || c == 8'h2B ||
           c == 8'h2D || c == 8'h2E || c == 8'h5F;
  endfunction

endpackage

// File: rtl/url_percent_codec.sv
`timescale 1ns / 1ps
// Top level of the URL percent codec: APB mode register, front end, queue and back end.
// Depends on upc_pkg, upc_front, upc_queue and upc_back.
//
// Form-urlencoded byte stream codec. Mode 0 encodes (space to '+', letters, digits and !'()*+-._
// copied, others to '%' and two lower-case hex digits); mode 1 decodes, and a last-marked
// input flushes a pending escape literally. The front end takes one input item every
// cycle while the command queue has room; the output register sends one byte per cycle
// while the sink is ready. An item yields one byte for most items, up to three for
// an escaped byte in encode mode or a flushed malformed escape in decode mode. Writing the
// mode register drops any pending escape; write it only while the codec is idle.
module url_percent_codec import upc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] in_byte
  input  logic              s_tlast,   // in_last
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic              m_tlast,   // out_last
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic     mode, cfg_wr, accept, push, full, pop, empty;
  upc_cmd_t cmd, head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_MODE);
  assign prdata = (paddr == ADDR_MODE) ? {31'd0, mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
    end else if (cfg_wr) begin
      mode <= pwdata[0];
    end
  end

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  upc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .mode    (mode),
    .clear   (cfg_wr),
    .accept  (accept),
    .in_byte (s_tdata),
    .in_last (s_tlast),
    .push    (push),
    .cmd     (cmd)
  );

  upc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  upc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: rtl/upc_front.sv
`timescale 1ns / 1ps
// Front end: classifies each input item and tracks the escape state while decoding.
// Produces at most one command of up to three output bytes per item. Depends on upc_pkg.
module upc_front import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       mode,
  input  logic       clear,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output upc_cmd_t   cmd
);

  typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIGIT} phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held, held_next;

  function automatic upc_cmd_t add_byte(input upc_cmd_t c, input logic [7:0] x);
    upc_cmd_t r;
    r = c;
    case (c.cnt)
      2'd0:    r.b0 = x;
      2'd1:    r.b1 = x;
      default: r.b2 = x;
    endcase
    r.cnt = c.cnt + 2'd1;
    return r;
  endfunction

  always_comb begin
    logic fresh;
    upc_cmd_t c;
    fresh      = 1'b0;
    c          = '0;
    c.last     = in_last;
    phase_next = phase;
    held_next  = held;
    if (mode == MODE_ENCODE) begin
      phase_next = PH_IDLE;
      if (in_byte == CH_SPACE) begin
        c = add_byte(c, CH_PLUS);
      end else if (passes(in_byte)) begin
        c = add_byte(c, in_byte);
      end else begin
        c = add_byte(c, CH_PCT);
        c = add_byte(c, hex_digit(in_byte[7:4]));
        c = add_byte(c, hex_digit(in_byte[3:0]));
      end
    end else begin
      case (phase)
        PH_PCT: begin
          if (is_hex(in_byte)) begin
            held_next  = in_byte;
            phase_next = PH_DIGIT;
          end else begin
            c     = add_byte(c, CH_PCT);
            fresh = 1'b1;
          end
        end
        PH_DIGIT: begin
          if (is_hex(in_byte)) begin
            c          = add_byte(c, {hex_val(held), hex_val(in_byte)});
            phase_next = PH_IDLE;
          end else begin
            c     = add_byte(c, CH_PCT);
            c     = add_byte(c, held);
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
      if (fresh) begin
        if (in_byte == CH_PCT) begin
          phase_next = PH_PCT;
        end else begin
          phase_next = PH_IDLE;
          c = add_byte(c, (in_byte == CH_PLUS) ? CH_SPACE : in_byte);
        end
      end
      // A last-marked item flushes whatever escape is still open.
      if (in_last) begin
        if (phase_next == PH_PCT) begin
          c = add_byte(c, CH_PCT);
        end else if (phase_next == PH_DIGIT) begin
          c = add_byte(c, CH_PCT);
          c = add_byte(c, held_next);
        end
        phase_next = PH_IDLE;
        held_next  = '0;
      end
    end
    cmd  = c;
    push = accept && (c.cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase <= PH_IDLE;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

// File: rtl/upc_queue.sv
`timescale 1ns / 1ps
// Small command queue between the front end and the output serializer; depends on upc_pkg.
// The user must keep the depth a power of two of at least two; the queue does not enforce it.
module upc_queue import upc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  upc_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output upc_cmd_t head,
  output logic     empty
);

  localparam int AW = $clog2(DEPTH);

  upc_cmd_t      mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == DEPTH[AW:0]);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/upc_back.sv
`timescale 1ns / 1ps
// Back end: walks the bytes of the head command into the output register, one a cycle while the sink takes them.
// Depends on upc_pkg.
module upc_back import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  upc_cmd_t   head,
  input  logic       empty,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  logic [1:0] idx;
  logic [7:0] sel_byte;
  logic       load, final_byte;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.b0;
      2'd1:    sel_byte = head.b1;
      default: sel_byte = head.b2;
    endcase
  end

  assign final_byte = (idx == head.cnt - 2'd1);
  assign load       = (!m_tvalid || m_tready) && !empty;
  assign pop        = load && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= final_byte ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= sel_byte;
      m_tlast <= head.last && final_byte;
    end
  end

endmodule
